// ===== hw/rtl/fsmk_pkg.sv =====
// Package for the flow shop makespan block: sizes, result word type,
// and the control group handed to each machine cell. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fsmk_pkg;

  localparam int MAX_MACHINES = 32;
  localparam int MACH_W       = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int TIME_W       = 32;
  localparam int PROC_W       = 16;
  localparam int CFG_W        = 6;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic adv;      // word accepted, move token and store at token cell
    logic restart;  // machine count written, token back to cell 0
  } fsmk_ctl_t;

  typedef struct packed {
    logic [TIME_W-1:0] completion_time;
    logic [MACH_W-1:0] machine_index;
    logic              is_makespan;
  } fsmk_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fsmk_cell.sv =====
// One machine cell: holds the completion time of one machine and the
// position token that walks the chain. Depends on fsmk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fsmk_cell import fsmk_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fsmk_ctl_t         ctl,
  input  wire logic              home,
  input  wire logic              is_last,
  input  wire logic              tok_in,
  input  wire logic [TIME_W-1:0] c_new,
  output logic                   pass_out,
  output logic                   wrap_out,
  output logic      [TIME_W-1:0] rd
);

  logic              tok;
  logic [TIME_W-1:0] val;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= home;
      val <= '0;
    end else if (ctl.restart) begin
      tok <= home;
    end else if (ctl.adv) begin
      tok <= tok_in;
      if (tok) begin
        val <= c_new;
      end
    end
  end

  assign pass_out = tok & ~is_last;
  assign wrap_out = tok & is_last;
  assign rd       = tok ? val : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/fsmk_obuf.sv =====
// Two-entry result buffer (output register plus skid) between the
// completion datapath and the result channel. Depends on fsmk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fsmk_obuf import fsmk_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire fsmk_res_t din,
  output logic           full,
  output logic           out_valid,
  input  wire logic      out_stall,
  output fsmk_res_t      dout
);

  logic      skid_valid;
  fsmk_res_t skid;
  logic      take;

  assign take = out_valid & ~out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid) begin
      out_valid <= push;
      if (push) begin
        dout <= din;
      end
    end else if (take) begin
      if (skid_valid) begin
        dout       <= skid;
        skid_valid <= 1'b0;
      end else if (push) begin
        dout <= din;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      skid       <= din;
      skid_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/flow_shop_makespan.sv =====
// Flow shop makespan top level: config register, completion datapath,
// machine cell chain and result buffer. Depends on fsmk_pkg, fsmk_cell, fsmk_obuf.
//
// Usage:
//   Config channel (cfg_valid/cfg_ready, num_machines): always ready; a write
//   sets the machine count (0 acts as 1, clamped to 32) and restarts at
//   machine 0 while keeping the stored completion row.
//   Input channel (in_valid/in_stall): one processing time per word, jobs in
//   sequence order, machines 0..m-1 within each job; first_job/last_job flag
//   the first and last job.
//   Output channel (out_valid/out_stall): one result word per input word:
//   completion time (saturating), its machine, and is_makespan on the last
//   machine of the last job.
//   The result is registered in the output buffer on accept; throughput one word per
//   cycle while in_stall is low, set by the combinational loop of row read, max, add and saturate.
//   A stalled result holds; one more word is taken into a skid entry, then
//   in_stall rises until the receiver drains.
//   Reset (rst, synchronous) clears the row to zero, sets one machine, and
//   empties the output.
`timescale 1ns / 1ps
`default_nettype none

module flow_shop_makespan import fsmk_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  num_machines,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [PROC_W-1:0] proc_time,
  input  wire logic              first_job,
  input  wire logic              last_job,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [TIME_W-1:0] completion_time,
  output logic      [MACH_W-1:0] machine_index,
  output logic                   is_makespan
);

  logic              cfg_wr;
  logic              acc;
  logic [MACH_W-1:0] k;
  logic [MACH_W-1:0] last_mach;
  logic [MACH_W-1:0] last_mach_next;
  logic [TIME_W-1:0] prev;
  logic [TIME_W-1:0] above;
  logic [TIME_W-1:0] left;
  logic [TIME_W-1:0] base;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] c;
  logic [TIME_W-1:0] row_rd;
  fsmk_ctl_t         ctl;
  fsmk_res_t         res;
  fsmk_res_t         res_out;

  logic [MAX_MACHINES-1:0] pass;
  logic [MAX_MACHINES-1:0] wrap;
  logic [MAX_MACHINES-1:0] tok_in;
  logic [TIME_W-1:0]       rd [MAX_MACHINES];

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign acc       = in_valid & ~in_stall;

  always_comb begin
    if (num_machines == '0) begin
      last_mach_next = '0;
    end else if (32'(num_machines) > MAX_MACHINES) begin
      last_mach_next = MACH_W'(MAX_MACHINES - 1);
    end else begin
      last_mach_next = MACH_W'(num_machines - CFG_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      prev      <= '0;
      last_mach <= '0;
    end else if (cfg_wr) begin
      k         <= '0;
      prev      <= '0;
      last_mach <= last_mach_next;
    end else if (acc) begin
      prev <= c;
      k    <= (k == last_mach) ? '0 : k + MACH_W'(1);
    end
  end

  assign ctl.adv     = acc & ~cfg_wr;
  assign ctl.restart = cfg_wr;

  assign tok_in = {pass[MAX_MACHINES-2:0], |wrap};

  for (genvar j = 0; j < MAX_MACHINES; j++) begin : g_cell
    fsmk_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .home     (j == 0),
      .is_last  (last_mach == MACH_W'(j)),
      .tok_in   (tok_in[j]),
      .c_new    (c),
      .pass_out (pass[j]),
      .wrap_out (wrap[j]),
      .rd       (rd[j])
    );
  end

  always_comb begin
    row_rd = '0;
    for (int j = 0; j < MAX_MACHINES; j++) begin
      row_rd = row_rd | rd[j];
    end
  end

  assign above = first_job ? '0 : row_rd;
  assign left  = (k == '0) ? '0 : prev;
  assign base  = (above > left) ? above : left;
  assign sum   = {1'b0, base} + {{(TIME_W + 1 - PROC_W){1'b0}}, proc_time};
  assign c     = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

  assign res.completion_time = c;
  assign res.machine_index   = k;
  assign res.is_makespan     = last_job & (k == last_mach);

  fsmk_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (acc),
    .din       (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (res_out)
  );

  assign completion_time = res_out.completion_time;
  assign machine_index   = res_out.machine_index;
  assign is_makespan     = res_out.is_makespan;

endmodule

`default_nettype wire

// ===== hw/rtl/fsmk_chk.sv =====
// Port-level checker for flow_shop_makespan, attached by bind.
// Depends on fsmk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fsmk_chk import fsmk_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [TIME_W-1:0] completion_time
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(completion_time))
    else $error("stalled result word changed");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result word pending");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall without a stalled result");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> out_valid)
    else $error("accepted word did not show next cycle");

endmodule

bind flow_shop_makespan fsmk_chk u_fsmk_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .completion_time (completion_time)
);

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for flow_shop_makespan: queue-fed driver, checking monitor, and
// a completion-row predictor. Depends on fsmk_pkg and the flow_shop_makespan RTL.
`timescale 1ns / 1ps

module tb;
  import fsmk_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_CAP   = 100;

  typedef struct packed {
    logic [PROC_W-1:0] proc_time;
    logic              first_job;
    logic              last_job;
  } shop_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  num_machines = '0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [PROC_W-1:0] proc_time    = '0;
  logic              first_job    = 1'b0;
  logic              last_job     = 1'b0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [TIME_W-1:0] completion_time;
  logic [MACH_W-1:0] machine_index;
  logic              is_makespan;

  flow_shop_makespan dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .num_machines    (num_machines),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .proc_time       (proc_time),
    .first_job       (first_job),
    .last_job        (last_job),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .completion_time (completion_time),
    .machine_index   (machine_index),
    .is_makespan     (is_makespan)
  );

  shop_word_t  pending_words[$];
  fsmk_res_t   completion_expect[$];

  logic [TIME_W-1:0] row_done[MAX_MACHINES];
  int unsigned       mach_pos     = 0;
  logic [TIME_W-1:0] prev_done    = '0;
  logic [CFG_W-1:0]  machines_cfg = 6'd1;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count      = 0;
  int unsigned cycle_count    = 0;

  initial begin
    for (int i = 0; i < MAX_MACHINES; i++) row_done[i] = '0;
  end

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= PRINT_CAP) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic int unsigned machines_used(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_MACHINES) return MAX_MACHINES;
    return 32'(v);
  endfunction

  // Advance the completion row by one accepted word and queue its result.
  task automatic predict_completion(shop_word_t w);
    int unsigned       m;
    int unsigned       k;
    logic [TIME_W-1:0] above;
    logic [TIME_W-1:0] left;
    logic [TIME_W-1:0] base;
    logic [TIME_W:0]   sum;
    fsmk_res_t         r;
    m = machines_used(machines_cfg);
    k = (mach_pos >= m) ? 0 : mach_pos;
    above = w.first_job ? '0 : row_done[k];
    left  = (k == 0) ? '0 : prev_done;
    base  = (above > left) ? above : left;
    sum   = {1'b0, base} + {{(TIME_W + 1 - PROC_W){1'b0}}, w.proc_time};
    r.completion_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    r.machine_index   = k[MACH_W-1:0];
    r.is_makespan     = w.last_job && (k + 1 == m);
    row_done[k] = r.completion_time;
    prev_done   = r.completion_time;
    mach_pos    = (k + 1 >= m) ? 0 : k + 1;
    completion_expect = {completion_expect, r};
  endtask

  task automatic check_result();
    fsmk_res_t want;
    if (completion_expect.size() == 0) begin
      flag_error($sformatf("result with nothing expected: time=%0d machine=%0d",
                           completion_time, machine_index));
      return;
    end
    want = completion_expect.pop_front();
    if (completion_time !== want.completion_time)
      flag_error($sformatf("completion_time %0d, expected %0d",
                           completion_time, want.completion_time));
    if (machine_index !== want.machine_index)
      flag_error($sformatf("machine_index %0d, expected %0d",
                           machine_index, want.machine_index));
    if (is_makespan !== want.is_makespan)
      flag_error($sformatf("is_makespan %0b, expected %0b (machine %0d)",
                           is_makespan, want.is_makespan, want.machine_index));
  endtask

  // Driver: holds a stalled word, otherwise sends or idles.
  always @(posedge clk) begin
    shop_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_completion('{proc_time, first_job, last_job});
      if (!(in_valid && in_stall)) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          w = pending_words.pop_front();
          in_valid  <= 1'b1;
          proc_time <= w.proc_time;
          first_job <= w.first_job;
          last_job  <= w.last_job;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_word(logic [PROC_W-1:0] p, logic f, logic l);
    shop_word_t w;
    w = '{p, f, l};
    pending_words = {pending_words, w};
  endtask

  function automatic logic [PROC_W-1:0] rand_time();
    logic [PROC_W-1:0] t;
    case ($urandom_range(7))
      0:       t = '0;
      1:       t = '1;
      2:       t = PROC_W'($urandom_range(15));
      default: t = PROC_W'($urandom_range(16'hFFFF));
    endcase
    return t;
  endfunction

  // Mostly well-formed job sequences, some jobs with random flags,
  // and sometimes a job cut short before the next machine count write.
  task automatic queue_random(int unsigned m, int unsigned target);
    int unsigned n;
    int unsigned jobs;
    logic        lead;
    n = 0;
    while (n < target) begin
      if ($urandom_range(9) < 7) begin
        jobs = $urandom_range(1, (m > 16) ? 2 : 5);
        lead = ($urandom_range(9) != 0);
        for (int j = 0; j < jobs; j++)
          for (int k = 0; k < m; k++)
            queue_word(rand_time(), (j == 0) && lead, j == jobs - 1);
        n += jobs * m;
      end else begin
        for (int k = 0; k < m; k++)
          queue_word(rand_time(), 1'($urandom_range(1)), 1'($urandom_range(1)));
        n += m;
      end
    end
    if ($urandom_range(1))
      repeat ($urandom_range(1, m))
        queue_word(rand_time(), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || completion_expect.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_machines(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_valid    <= 1'b1;
    num_machines <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    machines_cfg = v;
    mach_pos     = 0;
    prev_done    = '0;
  endtask

  initial begin
    logic [CFG_W-1:0] sweep[8];
    int unsigned      send_pct[4];
    int unsigned      stall_pct[4];
    sweep     = '{6'd2, 6'd32, 6'd33, 6'd7, 6'd1, 6'd17, 6'd0, 6'd63};
    sweep[6]  = CFG_W'($urandom_range(63));
    send_pct  = '{0, 70, 0, 11};
    stall_pct = '{0, 0, 70, 11};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: one machine after reset
    queue_word(16'd0, 1'b1, 1'b1);
    queue_word(16'hFFFF, 1'b1, 1'b1);
    queue_word(16'hFFFF, 1'b0, 1'b1);
    queue_word(16'd1, 1'b0, 1'b0);
    wait_drained();

    // Three machines: first job, flags changing inside a job, last job,
    // then a partial job cut by the next write
    set_machines(6'd3);
    queue_word(16'hFFFF, 1'b1, 1'b0);
    queue_word(16'd0, 1'b1, 1'b0);
    queue_word(16'hFFFF, 1'b1, 1'b0);
    queue_word(16'd1, 1'b0, 1'b0);
    queue_word(16'hFFFF, 1'b1, 1'b1);
    queue_word(16'd2, 1'b0, 1'b1);
    queue_word(16'd0, 1'b0, 1'b1);
    queue_word(16'd0, 1'b0, 1'b1);
    queue_word(16'd0, 1'b0, 1'b1);
    queue_word(16'd5, 1'b0, 1'b0);
    queue_word(16'd6, 1'b0, 1'b1);
    wait_drained();

    // Zero machines acts as one
    set_machines(6'd0);
    queue_word(16'd7, 1'b1, 1'b1);
    queue_word(16'd8, 1'b0, 1'b1);
    wait_drained();

    // 63 clamps to the full row
    set_machines(6'd63);
    queue_word(16'h5555, 1'b0, 1'b1);
    queue_word(16'hAAAA, 1'b1, 1'b1);
    queue_word(16'd3, 1'b0, 1'b0);
    wait_drained();

    for (int i = 0; i < 8; i++) begin
      set_machines(sweep[i]);
      send_idle_pct  = send_pct[i % 4];
      recv_stall_pct = stall_pct[i % 4];
      queue_random(machines_used(sweep[i]), 35);
      wait_drained();
    end

    // One machine, a run of maximum times
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_machines(6'd1);
    queue_word(16'hFFFF, 1'b1, 1'b0);
    repeat (20) queue_word(16'hFFFF, 1'b0, 1'b0);
    queue_word(16'd0, 1'b0, 1'b1);
    queue_word(16'd9, 1'b1, 1'b1);
    wait_drained();

    repeat (10) @(posedge clk);
    if (err_count == 0 && completion_expect.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
